FILE: rtl/mtkr_pkg.sv
// ============================================================================
// Mod-tap key resolver package
// Shared operation codes, result kinds, sequencer states and beat structures.
// ============================================================================
`default_nettype none

package mtkr_pkg;

    // Operation code of an input beat
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_KEY     = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Kind of a result beat
    typedef enum logic [3:0] {
        KIND_PASS       = 4'd0,
        KIND_CAPTURED   = 4'd1,
        KIND_DROPPED    = 4'd2,
        KIND_RECORDED   = 4'd3,
        KIND_FULL       = 4'd4,
        KIND_NO_MATCH   = 4'd5,
        KIND_REGISTER   = 4'd6,
        KIND_UNREGISTER = 4'd7,
        KIND_KEY        = 4'd8,
        KIND_REPORT     = 4'd9
    } t_kind;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HSCAN,
        ST_CSCAN,
        ST_DECIDE,
        ST_SINGLE,
        ST_REG,
        ST_KEY_PRESS,
        ST_TAP_PRESS,
        ST_FLUSH,
        ST_TAP_REL,
        ST_UNREG,
        ST_REPORT
    } t_state;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  mods;
        logic [15:0] page;
        logic [15:0] code;
        logic        pressed;
        logic        last;
    } t_beat;

    // Flags from the shared slot compare unit
    typedef struct packed {
        logic h_free;
        logic h_match;
        logic c_free;
        logic c_match;
    } t_cmp;

    localparam logic [15:0] TAP_PAGE_RESET = 16'd7;

endpackage

`default_nettype wire

FILE: rtl/mtkr_slot_cmp.sv
// ============================================================================
// Mod-tap slot compare unit
// Compares one held binding slot and one capture slot against the current beat.
// ============================================================================
`default_nettype none

module mtkr_slot_cmp (
    input  wire logic [7:0]   i_held_mods,
    input  wire logic [15:0]  i_held_code,
    input  wire logic         i_cap_valid,
    input  wire logic [15:0]  i_cap_code,
    input  wire logic [7:0]   i_mods,
    input  wire logic [15:0]  i_code,
    output mtkr_pkg::t_cmp    o_flags
);

    always_comb begin
        o_flags.h_free  = (i_held_mods == 8'd0);
        o_flags.h_match = (i_held_mods == i_mods) && (i_held_code == i_code);
        o_flags.c_free  = !i_cap_valid;
        o_flags.c_match = i_cap_valid && (i_cap_code == i_code);
    end

endmodule

`default_nettype wire

FILE: rtl/mtkr_out_reg.sv
// ============================================================================
// Mod-tap result register
// Holds one result beat until the downstream side takes it.
// ============================================================================
`default_nettype none

module mtkr_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire mtkr_pkg::t_beat  i_beat,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output mtkr_pkg::t_beat       o_beat,
    output logic                  o_free
);

    logic            r_valid;
    mtkr_pkg::t_beat r_beat;

    // Control: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_beat      = r_beat;

endmodule

`default_nettype wire

FILE: rtl/mod_tap_key_resolver_unit.sv
// ============================================================================
// Mod-tap key resolver
// Tracks held mod-tap bindings and captured key presses, emits result beats.
// ============================================================================
// Sequence: a scan of every held slot (then of every capture slot for key events),
//   a decide step, then one result beat per cycle while the output is free; a
//   tap flush walks every capture slot in order, emitting each captured key on the way.
// A new input beat is taken only once the previous one is finished and the sequencer is idle.
// Reset: synchronous; clears held table, capture flags and mods; tap page 7.
`default_nettype none

module mod_tap_key_resolver_unit #(
    parameter int HELD_SLOTS    = 4,
    parameter int CAPTURE_SLOTS = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration: tap usage page
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    // Input channel
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_operation,
    input  wire logic [7:0]   i_mods,
    input  wire logic [15:0]  i_keycode,
    input  wire logic         i_key_state,
    input  wire logic [15:0]  i_usage_page,
    // Output channel
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [3:0]        o_kind,
    output logic [7:0]        o_mods_out,
    output logic [15:0]       o_page_out,
    output logic [15:0]       o_code_out,
    output logic              o_pressed_out,
    output logic              o_last
);

    // Index widths: one shared scan counter walks both tables
    localparam int HW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam int CW = (CAPTURE_SLOTS > 1) ? $clog2(CAPTURE_SLOTS) : 1;
    localparam int IW = (HW > CW) ? HW : CW;
    localparam logic [IW-1:0] HELD_LAST = IW'(HELD_SLOTS - 1);
    localparam logic [IW-1:0] CAP_LAST  = IW'(CAPTURE_SLOTS - 1);

    // ------------------------------------------------------------------
    // Tables
    // ------------------------------------------------------------------
    logic [7:0]  r_held_mods  [HELD_SLOTS];
    logic [15:0] r_held_code  [HELD_SLOTS];
    logic        r_held_pend  [HELD_SLOTS];
    logic [7:0]  r_held_prior [HELD_SLOTS];

    logic        r_cap_valid  [CAPTURE_SLOTS];
    logic [7:0]  r_cap_mods   [CAPTURE_SLOTS];
    logic [15:0] r_cap_page   [CAPTURE_SLOTS];
    logic [15:0] r_cap_code   [CAPTURE_SLOTS];

    logic [15:0] r_tap_page;

    // ------------------------------------------------------------------
    // Sequencer and work registers
    // ------------------------------------------------------------------
    mtkr_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;

    mtkr_pkg::t_op    r_op, n_op;
    logic [7:0]       r_mods, n_mods;
    logic [15:0]      r_code, n_code;
    logic             r_kstate, n_kstate;
    logic [15:0]      r_page, n_page;

    logic [7:0]       r_acc_or, n_acc_or;     // OR of held mods
    logic             r_hok, n_hok;           // held slot found
    logic [HW-1:0]    r_hfound, n_hfound;
    logic [7:0]       r_hprior, n_hprior;
    logic             r_hpend, n_hpend;
    logic             r_cok, n_cok;           // capture slot found
    logic [CW-1:0]    r_cfound, n_cfound;
    logic [7:0]       r_cmods, n_cmods;
    logic [15:0]      r_cpage, n_cpage;
    logic [7:0]       r_emods, n_emods;       // mods for register/unregister beats
    mtkr_pkg::t_kind  r_kind, n_kind;         // kind of the closing single beat

    // Decoded table updates
    logic             w_hold_wr;
    logic             w_hold_clr;
    logic             w_settle;
    logic [7:0]       w_settle_mask;
    logic             w_cap_wr;
    logic             w_cap_clr;
    logic [CW-1:0]    w_cap_clr_idx;

    logic [HW-1:0]    w_hidx;
    logic [CW-1:0]    w_cidx;
    mtkr_pkg::t_cmp   w_flags;
    logic             w_hsel;
    logic             w_csel;
    logic             w_adv;
    logic             w_tap_last;

    // Result register hookup
    logic             w_load;
    mtkr_pkg::t_beat  w_beat;
    mtkr_pkg::t_beat  w_obeat;
    logic             w_free;

    assign w_hidx = r_idx[HW-1:0];
    assign w_cidx = r_idx[CW-1:0];

    // Shared compare unit: sees the slot at the scan counter in each table
    mtkr_slot_cmp u_cmp (
        .i_held_mods (r_held_mods[w_hidx]),
        .i_held_code (r_held_code[w_hidx]),
        .i_cap_valid (r_cap_valid[w_cidx]),
        .i_cap_code  (r_cap_code[w_cidx]),
        .i_mods      (r_mods),
        .i_code      (r_code),
        .o_flags     (w_flags)
    );

    mtkr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_beat      (w_beat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_beat      (w_obeat),
        .o_free      (w_free)
    );

    assign o_kind        = w_obeat.kind;
    assign o_mods_out    = w_obeat.mods;
    assign o_page_out    = w_obeat.page;
    assign o_code_out    = w_obeat.code;
    assign o_pressed_out = w_obeat.pressed;
    assign o_last        = w_obeat.last;

    // Accept a new input beat only between items
    assign o_in_stall = (r_state != mtkr_pkg::ST_IDLE);

    assign w_hsel     = (r_op == mtkr_pkg::OP_PRESS) ? w_flags.h_free : w_flags.h_match;
    assign w_csel     = r_kstate ? w_flags.c_free : w_flags.c_match;
    assign w_tap_last = (r_hprior == 8'd0);

    // ------------------------------------------------------------------
    // Sequencer: next state, work registers and result beats
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_op      = r_op;
        n_mods    = r_mods;
        n_code    = r_code;
        n_kstate  = r_kstate;
        n_page    = r_page;
        n_acc_or  = r_acc_or;
        n_hok     = r_hok;
        n_hfound  = r_hfound;
        n_hprior  = r_hprior;
        n_hpend   = r_hpend;
        n_cok     = r_cok;
        n_cfound  = r_cfound;
        n_cmods   = r_cmods;
        n_cpage   = r_cpage;
        n_emods   = r_emods;
        n_kind    = r_kind;

        w_hold_wr     = 1'b0;
        w_hold_clr    = 1'b0;
        w_settle      = 1'b0;
        w_settle_mask = 8'd0;
        w_cap_wr      = 1'b0;
        w_cap_clr     = 1'b0;
        w_cap_clr_idx = r_cfound;
        w_adv         = 1'b0;

        w_load = 1'b0;
        w_beat = '0;

        case (r_state)
            mtkr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = mtkr_pkg::t_op'(i_operation);
                    n_mods   = i_mods;
                    n_code   = i_keycode;
                    n_kstate = i_key_state;
                    n_page   = i_usage_page;
                    n_idx    = '0;
                    n_acc_or = 8'd0;
                    n_hok    = 1'b0;
                    n_cok    = 1'b0;
                    // The unused operation code is swallowed without a result
                    if (mtkr_pkg::t_op'(i_operation) != mtkr_pkg::OP_NONE) begin
                        n_state = mtkr_pkg::ST_HSCAN;
                    end
                end
            end

            mtkr_pkg::ST_HSCAN: begin
                n_acc_or = r_acc_or | r_held_mods[w_hidx];
                if (w_hsel && !r_hok) begin
                    n_hok    = 1'b1;
                    n_hfound = w_hidx;
                    n_hprior = r_held_prior[w_hidx];
                    n_hpend  = r_held_pend[w_hidx];
                end
                if (r_idx == HELD_LAST) begin
                    n_idx   = '0;
                    n_state = (r_op == mtkr_pkg::OP_KEY) ? mtkr_pkg::ST_CSCAN
                                                         : mtkr_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            mtkr_pkg::ST_CSCAN: begin
                if (w_csel && !r_cok) begin
                    n_cok    = 1'b1;
                    n_cfound = w_cidx;
                    n_cmods  = r_cap_mods[w_cidx];
                    n_cpage  = r_cap_page[w_cidx];
                end
                if (r_idx == CAP_LAST) begin
                    n_idx   = '0;
                    n_state = mtkr_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            mtkr_pkg::ST_DECIDE: begin
                n_state = mtkr_pkg::ST_SINGLE;
                case (r_op)
                    mtkr_pkg::OP_PRESS: begin
                        w_hold_wr = r_hok;
                        n_kind    = r_hok ? mtkr_pkg::KIND_RECORDED : mtkr_pkg::KIND_FULL;
                    end
                    mtkr_pkg::OP_RELEASE: begin
                        if (!r_hok) begin
                            n_kind = mtkr_pkg::KIND_NO_MATCH;
                        end else begin
                            w_hold_clr = 1'b1;
                            if (r_hpend) begin
                                n_emods = r_hprior;
                                if (r_hprior != 8'd0) begin
                                    w_settle      = 1'b1;
                                    w_settle_mask = r_hprior;
                                    n_state       = mtkr_pkg::ST_REG;
                                end else begin
                                    n_state = mtkr_pkg::ST_TAP_PRESS;
                                end
                            end else begin
                                n_emods = r_mods;
                                n_state = mtkr_pkg::ST_UNREG;
                            end
                        end
                    end
                    mtkr_pkg::OP_KEY: begin
                        n_kind = mtkr_pkg::KIND_PASS;
                        if (r_acc_or != 8'd0) begin
                            if (r_kstate) begin
                                w_cap_wr = r_cok;
                                n_kind   = r_cok ? mtkr_pkg::KIND_CAPTURED
                                                 : mtkr_pkg::KIND_DROPPED;
                            end else if (r_cok) begin
                                // Captured key released: register its mods, replay it
                                w_settle      = 1'b1;
                                w_settle_mask = r_cmods;
                                w_cap_clr     = 1'b1;
                                n_emods       = r_cmods;
                                n_state       = mtkr_pkg::ST_REG;
                            end
                        end
                    end
                    default: begin
                        n_state = mtkr_pkg::ST_IDLE;
                    end
                endcase
            end

            mtkr_pkg::ST_SINGLE: begin
                if (w_free) begin
                    w_load      = 1'b1;
                    w_beat.kind = r_kind;
                    w_beat.last = 1'b1;
                    n_state     = mtkr_pkg::ST_IDLE;
                end
            end

            mtkr_pkg::ST_REG: begin
                if (w_free) begin
                    w_load      = 1'b1;
                    w_beat.kind = mtkr_pkg::KIND_REGISTER;
                    w_beat.mods = r_emods;
                    n_state     = (r_op == mtkr_pkg::OP_RELEASE) ? mtkr_pkg::ST_TAP_PRESS
                                                                 : mtkr_pkg::ST_KEY_PRESS;
                end
            end

            mtkr_pkg::ST_KEY_PRESS: begin
                if (w_free) begin
                    w_load         = 1'b1;
                    w_beat.kind    = mtkr_pkg::KIND_KEY;
                    w_beat.page    = r_cpage;
                    w_beat.code    = r_code;
                    w_beat.pressed = 1'b1;
                    n_state        = mtkr_pkg::ST_SINGLE;
                end
            end

            mtkr_pkg::ST_TAP_PRESS: begin
                if (w_free) begin
                    w_load         = 1'b1;
                    w_beat.kind    = mtkr_pkg::KIND_KEY;
                    w_beat.page    = r_tap_page;
                    w_beat.code    = r_code;
                    w_beat.pressed = 1'b1;
                    n_idx          = '0;
                    n_state        = mtkr_pkg::ST_FLUSH;
                end
            end

            mtkr_pkg::ST_FLUSH: begin
                if (r_cap_valid[w_cidx]) begin
                    if (w_free) begin
                        w_load         = 1'b1;
                        w_beat.kind    = mtkr_pkg::KIND_KEY;
                        w_beat.page    = r_cap_page[w_cidx];
                        w_beat.code    = r_cap_code[w_cidx];
                        w_beat.pressed = 1'b1;
                        w_cap_clr      = 1'b1;
                        w_cap_clr_idx  = w_cidx;
                        w_adv          = 1'b1;
                    end
                end else begin
                    w_adv = 1'b1;
                end
                if (w_adv) begin
                    if (r_idx == CAP_LAST) begin
                        n_idx   = '0;
                        n_state = mtkr_pkg::ST_TAP_REL;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            mtkr_pkg::ST_TAP_REL: begin
                if (w_free) begin
                    w_load      = 1'b1;
                    w_beat.kind = mtkr_pkg::KIND_KEY;
                    w_beat.page = r_tap_page;
                    w_beat.code = r_code;
                    w_beat.last = w_tap_last;
                    n_state     = w_tap_last ? mtkr_pkg::ST_IDLE : mtkr_pkg::ST_UNREG;
                end
            end

            mtkr_pkg::ST_UNREG: begin
                if (w_free) begin
                    w_load      = 1'b1;
                    w_beat.kind = mtkr_pkg::KIND_UNREGISTER;
                    w_beat.mods = r_emods;
                    n_state     = mtkr_pkg::ST_REPORT;
                end
            end

            mtkr_pkg::ST_REPORT: begin
                if (w_free) begin
                    w_load      = 1'b1;
                    w_beat.kind = mtkr_pkg::KIND_REPORT;
                    w_beat.last = 1'b1;
                    n_state     = mtkr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mtkr_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtkr_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Work registers: every field is loaded before it is read
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_mods   <= n_mods;
        r_code   <= n_code;
        r_kstate <= n_kstate;
        r_page   <= n_page;
        r_acc_or <= n_acc_or;
        r_hok    <= n_hok;
        r_hfound <= n_hfound;
        r_hprior <= n_hprior;
        r_hpend  <= n_hpend;
        r_cok    <= n_cok;
        r_cfound <= n_cfound;
        r_cmods  <= n_cmods;
        r_cpage  <= n_cpage;
        r_emods  <= n_emods;
        r_kind   <= n_kind;
    end

    // Tap usage page register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_page <= mtkr_pkg::TAP_PAGE_RESET;
        end else if (i_cfg_we) begin
            r_tap_page <= i_cfg_wdata;
        end
    end

    // Held binding table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HELD_SLOTS; k++) begin
                r_held_mods[k]  <= 8'd0;
                r_held_code[k]  <= 16'd0;
                r_held_pend[k]  <= 1'b0;
                r_held_prior[k] <= 8'd0;
            end
        end else begin
            // Settle: drop pending on every slot whose mods are covered by the mask
            if (w_settle) begin
                for (int k = 0; k < HELD_SLOTS; k++) begin
                    if ((r_held_mods[k] & w_settle_mask) == r_held_mods[k]) begin
                        r_held_pend[k] <= 1'b0;
                    end
                end
            end
            if (w_hold_wr) begin
                r_held_mods[r_hfound]  <= r_mods;
                r_held_code[r_hfound]  <= r_code;
                r_held_pend[r_hfound]  <= 1'b1;
                r_held_prior[r_hfound] <= r_acc_or;
            end
            // Release: strip released mods from every prior mask, free the slot
            // (the pending bit of a freed slot is kept)
            if (w_hold_clr) begin
                for (int k = 0; k < HELD_SLOTS; k++) begin
                    r_held_prior[k] <= r_held_prior[k] & ~r_mods;
                end
                r_held_mods[r_hfound]  <= 8'd0;
                r_held_code[r_hfound]  <= 16'd0;
                r_held_prior[r_hfound] <= 8'd0;
            end
        end
    end

    // Capture table control: valid bits and tag mods
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CAPTURE_SLOTS; k++) begin
                r_cap_valid[k] <= 1'b0;
                r_cap_mods[k]  <= 8'd0;
            end
        end else begin
            if (w_cap_wr) begin
                r_cap_valid[r_cfound] <= 1'b1;
                r_cap_mods[r_cfound]  <= r_acc_or;
            end
            if (w_cap_clr) begin
                r_cap_valid[w_cap_clr_idx] <= 1'b0;
                r_cap_mods[w_cap_clr_idx]  <= 8'd0;
            end
        end
    end

    // Capture table payload, read only behind a valid bit
    always_ff @(posedge i_clk) begin
        if (w_cap_wr) begin
            r_cap_page[r_cfound] <= r_page;
            r_cap_code[r_cfound] <= r_code;
        end
    end

`ifndef SYNTHESIS
    // A report beat always closes its item
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == mtkr_pkg::KIND_REPORT) |-> o_last)
        else $error("report beat without last");

    // Key event beats never carry modifier bits
    a_key_no_mods: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == mtkr_pkg::KIND_KEY) |-> (o_mods_out == 8'd0))
        else $error("key event beat carries mods");

    // The ignored operation code leaves the sequencer idle
    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == mtkr_pkg::OP_NONE)
        |=> (r_state == mtkr_pkg::ST_IDLE))
        else $error("ignored operation started a scan");

    // The held scan never walks past the table
    a_hscan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtkr_pkg::ST_HSCAN) |-> (r_idx <= HELD_LAST))
        else $error("held scan index out of range");
`endif

endmodule

`default_nettype wire
